@@ hdl/tcw_pkg.sv @@
// Shared types and constants for the text console character writer.
// Depends on nothing; every other file of the block refers to it by scoped names.
package tcw_pkg;

    // Fixed widths of the transfer fields.
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int CURSOR_W = 11;
    localparam int CELL_W   = 16;
    localparam int ATTR_W   = 8;

    // Action codes.
    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Character codes with a meaning of their own.
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

    // Attribute after reset.
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_CLEAR,
        ST_SPACE,
        ST_DONE
    } tcw_state_t;

    // Finished result handed from the sequencer to the output register.
    typedef struct packed {
        logic                done;
        logic [CURSOR_W-1:0] cursor_position;
        logic [CELL_W-1:0]   cell_value;
        logic                scrolled;
    } tcw_result_t;

endpackage

@@ hdl/tcw_cell_ram.sv @@
// Screen cell store: one write port and one read port with registered read data.
// Depends on tcw_pkg for the cell width.
module tcw_cell_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [tcw_pkg::CELL_W-1:0] rd_data
);

    logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data registered and valid in the cycle after the address.
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/tcw_sequencer.sv @@
// Sequencer for the text console: cursor update, scroll copy, row clear and reads.
// Depends on tcw_pkg; drives the ports of tcw_cell_ram through one shared address counter.
module tcw_sequencer #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int USED_ROWS = 24,
    parameter int ADDR_W    = 11
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [tcw_pkg::CHAR_W-1:0]    s_char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]   s_cell_index,
    input  logic [tcw_pkg::ATTR_W-1:0]    text_attr,
    input  logic                          out_free,
    output tcw_pkg::tcw_result_t          result,
    output logic                          mem_we,
    output logic [ADDR_W-1:0]             mem_waddr,
    output logic [tcw_pkg::CELL_W-1:0]    mem_wdata,
    output logic [ADDR_W-1:0]             mem_raddr,
    input  logic [tcw_pkg::CELL_W-1:0]    mem_rdata
);

    localparam int VIS_CELLS   = COLUMNS * ROWS;
    localparam int LIVE_CELLS  = COLUMNS * USED_ROWS;
    localparam int STORE_CELLS = (VIS_CELLS > LIVE_CELLS) ? VIS_CELLS : LIVE_CELLS + COLUMNS;
    localparam int COL_W       = $clog2(COLUMNS);

    localparam logic [ADDR_W-1:0] COLS_A       = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LIVE_A       = ADDR_W'(LIVE_CELLS);
    localparam logic [ADDR_W-1:0] COPY_A       = ADDR_W'(LIVE_CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_LIVE_A  = ADDR_W'(LIVE_CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_STORE_A = ADDR_W'(STORE_CELLS - 1);
    localparam logic [COL_W-1:0]  LAST_COL     = COL_W'(COLUMNS - 1);

    tcw_pkg::tcw_state_t  state_reg, state_next;
    logic [ADDR_W-1:0]    cnt_reg, cnt_next;
    logic [ADDR_W-1:0]    cursor_reg, cursor_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic                 scrolled_reg, scrolled_next;
    logic                 in_range_reg, in_range_next;
    tcw_pkg::tcw_result_t result_reg, result_next;

    logic [ADDR_W-1:0] pos0;
    logic [COL_W-1:0]  col0;
    logic [ADDR_W-1:0] new_pos;
    logic [COL_W-1:0]  new_col;
    logic              write_char;
    logic              accept;

    assign accept = s_valid && s_ready;
    assign result = result_reg;

    // Cursor arithmetic for a put; the column is tracked next to the cell index.
    always_comb begin
        if (cursor_reg >= LIVE_A) begin
            pos0 = '0;
            col0 = '0;
        end else begin
            pos0 = cursor_reg;
            col0 = col_reg;
        end
        write_char = 1'b0;
        case (s_char_code)
            tcw_pkg::CHAR_NEWLINE: begin
                new_pos = pos0 + (COLS_A - ADDR_W'(col0));
                new_col = '0;
            end
            tcw_pkg::CHAR_BACKSPACE: begin
                if (pos0 != '0) begin
                    new_pos = pos0 - 1'b1;
                    new_col = (col0 == '0) ? LAST_COL : col0 - 1'b1;
                end else begin
                    new_pos = pos0;
                    new_col = col0;
                end
            end
            default: begin
                write_char = 1'b1;
                new_pos    = pos0 + 1'b1;
                new_col    = (col0 == LAST_COL) ? '0 : col0 + 1'b1;
            end
        endcase
    end

    // State and data registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= tcw_pkg::ST_INIT;
            cnt_reg    <= '0;
            cursor_reg <= '0;
            col_reg    <= '0;
            result_reg <= '0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        scrolled_reg <= scrolled_next;
        in_range_reg <= in_range_next;
    end

    // Next state, memory port control and result.
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cursor_next   = cursor_reg;
        col_next      = col_reg;
        scrolled_next = scrolled_reg;
        in_range_next = in_range_reg;
        result_next   = result_reg;
        result_next.done = 1'b0;
        s_ready       = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = cnt_reg;
        mem_wdata     = '0;
        mem_raddr     = cnt_reg + COLS_A;

        case (state_reg)
            // Clearing pass over the whole store after reset.
            tcw_pkg::ST_INIT: begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STORE_A) begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end

            tcw_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                mem_raddr = ADDR_W'(s_cell_index);
                if (accept) begin
                    if (s_action == tcw_pkg::ACT_READ) begin
                        in_range_next = (32'(s_cell_index) < 32'(VIS_CELLS));
                        state_next    = tcw_pkg::ST_READ;
                    end else begin
                        mem_we    = write_char;
                        mem_waddr = pos0;
                        mem_wdata = {text_attr, s_char_code};
                        col_next  = new_col;
                        cnt_next  = '0;
                        if (new_pos >= LIVE_A) begin
                            cursor_next   = new_pos - COLS_A;
                            scrolled_next = 1'b1;
                            state_next    = tcw_pkg::ST_COPY;
                        end else begin
                            cursor_next   = new_pos;
                            scrolled_next = 1'b0;
                            state_next    = tcw_pkg::ST_SPACE;
                        end
                    end
                end
            end

            tcw_pkg::ST_READ: begin
                result_next.cursor_position = tcw_pkg::CURSOR_W'(cursor_reg);
                result_next.cell_value      = in_range_reg ? mem_rdata : '0;
                result_next.scrolled        = 1'b0;
                state_next                  = tcw_pkg::ST_DONE;
            end

            // Move rows up: read one row ahead and write the word read in the previous cycle.
            tcw_pkg::ST_COPY: begin
                if (cnt_reg != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_reg - 1'b1;
                    mem_wdata = mem_rdata;
                end
                if (cnt_reg == COPY_A) begin
                    cnt_next   = cursor_reg;
                    state_next = tcw_pkg::ST_CLEAR;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Blank the cells from the cursor to the end of the last live row.
            tcw_pkg::ST_CLEAR: begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_LIVE_A) begin
                    state_next = tcw_pkg::ST_SPACE;
                end
            end

            tcw_pkg::ST_SPACE: begin
                mem_we    = 1'b1;
                mem_waddr = cursor_reg;
                mem_wdata = {text_attr, tcw_pkg::CHAR_SPACE};
                result_next.cursor_position = tcw_pkg::CURSOR_W'(cursor_reg);
                result_next.cell_value      = '0;
                result_next.scrolled        = scrolled_reg;
                state_next                  = tcw_pkg::ST_DONE;
            end

            // Hold the result until the output register can take it.
            tcw_pkg::ST_DONE: begin
                result_next.done = !out_free;
                if (out_free) begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase

        if (state_next == tcw_pkg::ST_DONE) begin
            result_next.done = 1'b1;
        end
    end

endmodule

@@ hdl/text_console_char_writer.sv @@
// Top level of the text console character writer: attribute register and output register.
// Depends on tcw_pkg, tcw_cell_ram and tcw_sequencer.
//
// A put writes one character (newline and backspace write none) into a COLUMNS x ROWS
// screen store and moves the cursor; a read returns one cell. Every accepted item gives
// exactly one result transfer. After reset the block clears the whole store, one cell a
// cycle, and takes no item until that pass ends; attribute writes are taken at any time.
// A read passes through ST_READ and a put that does not scroll through ST_SPACE before
// the result is offered. A put that scrolls moves USED_ROWS-1 rows up and blanks one row
// through the single write port of the store, one cell a cycle, before ST_SPACE. One item
// is worked on at a time; the next item is taken once the result sits in the output
// register.
module text_console_char_writer #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int USED_ROWS = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0]      cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_action,
    input  logic [tcw_pkg::CHAR_W-1:0]      s_char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]     s_cell_index,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tcw_pkg::CURSOR_W-1:0]    m_cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]      m_cell_value,
    output logic                            m_scrolled
);

    localparam int VIS_CELLS   = COLUMNS * ROWS;
    localparam int LIVE_CELLS  = COLUMNS * USED_ROWS;
    localparam int STORE_CELLS = (VIS_CELLS > LIVE_CELLS) ? VIS_CELLS : LIVE_CELLS + COLUMNS;
    localparam int ADDR_W      = $clog2(STORE_CELLS);

    logic [tcw_pkg::ATTR_W-1:0]   attr_reg, attr_next;
    logic                         m_valid_reg, m_valid_next;
    logic [tcw_pkg::CURSOR_W-1:0] cursor_out_reg;
    logic [tcw_pkg::CELL_W-1:0]   value_out_reg;
    logic                         scrolled_out_reg;
    logic                         out_free;
    logic                         load_out;
    tcw_pkg::tcw_result_t         seq_result;

    logic                         mem_we;
    logic [ADDR_W-1:0]            mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]            mem_raddr;
    logic [tcw_pkg::CELL_W-1:0]   mem_rdata;

    // Attribute register.
    always_comb begin
        attr_next = cfg_wr_en ? cfg_wr_data : attr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= tcw_pkg::ATTR_RESET;
        end else begin
            attr_reg <= attr_next;
        end
    end

    tcw_sequencer #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .USED_ROWS (USED_ROWS),
        .ADDR_W    (ADDR_W)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_char_code  (s_char_code),
        .s_cell_index (s_cell_index),
        .text_attr    (attr_reg),
        .out_free     (out_free),
        .result       (seq_result),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    tcw_cell_ram #(
        .DEPTH  (STORE_CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Output register: loads a finished result whenever the slot is empty or being emptied.
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = seq_result.done && out_free;

    always_comb begin
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            cursor_out_reg   <= seq_result.cursor_position;
            value_out_reg    <= seq_result.cell_value;
            scrolled_out_reg <= seq_result.scrolled;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_cursor_position = cursor_out_reg;
    assign m_cell_value      = value_out_reg;
    assign m_scrolled        = scrolled_out_reg;

`ifndef SYNTH
    // The cursor reported with any result stays inside the live rows.
    a_cursor_live: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_result.done |-> (32'(seq_result.cursor_position) < 32'(LIVE_CELLS)))
        else $error("cursor outside the live rows");

    // A scroll always leaves the cursor at the start of the last live row.
    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_result.done && seq_result.scrolled) |->
        (32'(seq_result.cursor_position) == 32'(LIVE_CELLS - COLUMNS)))
        else $error("scroll left the cursor off the last live row start");

    // One item at a time: the input closes right after a transfer.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in work");

    // A result is only loaded into an empty or draining output slot.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_cursor_position) && $stable(m_cell_value)))
        else $error("output result overwritten before its transfer");
`endif

endmodule
